/* rtl/core/chm3k_pkg.sv */
// package for the chained hash map unit: state encoding, field widths and
// parameter defaults shared by the top level and its port checker
// no dependencies
package chm3k_pkg;

  localparam int unsigned BUCKETS_DEF    = 4673;
  localparam int unsigned POOL_NODES_DEF = 1024;
  localparam int unsigned VALUE_BITS_DEF = 16;

  // fixed port widths
  localparam int unsigned KEY_W = 24;
  localparam int unsigned VAL_W = 16;

  // |signed byte * signed byte| never exceeds 16384
  localparam int unsigned MAG_W     = 15;
  // reciprocal scale for the bucket reduction, must exceed MAG_W
  localparam int unsigned RCP_SHIFT = 16;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RCP,
    S_QB,
    S_RED,
    S_IDX,
    S_HRD,
    S_HEAD,
    S_NODE,
    S_LINK
  } state_e;

endpackage

/* rtl/core/chained_hash_map_3byte_key_unit.sv */
// top level of the chained hash map: bucket index reduction, head table and
// node pool memories, chain walk sequencer and result register
// depends on chm3k_pkg

// After reset the unit runs a clearing pass over all BUCKETS entries of the
// head table (4673 by default); busy stays high during it. Then one command
// word is taken at a time. An accepted command passes through the reciprocal
// multiply, quotient product, reduction and index states of the bucket
// reduction, then the registered head table read. A command whose bucket head
// settles it gives its result strobe in the same cycle that busy drops, so the
// next command may follow in that cycle. The chain walk does one read of the
// node pool memory per cycle, one for each chain node that is visited, and an
// insert appended behind a chain node then writes back the old tail's link in
// a separate link state. The done_o strobe lasts exactly one cycle
// and cannot be held off, so the receiver must take it when it appears.
module chained_hash_map_3byte_key_unit #(
  parameter int unsigned BUCKETS    = chm3k_pkg::BUCKETS_DEF,
  parameter int unsigned POOL_NODES = chm3k_pkg::POOL_NODES_DEF,
  parameter int unsigned VALUE_BITS = chm3k_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind_i,
  input  logic [chm3k_pkg::KEY_W-1:0]  char_key_i,
  input  logic [chm3k_pkg::VAL_W-1:0]  entry_value_i,
  output logic                         done_o,
  output logic                         found_o,
  output logic [chm3k_pkg::VAL_W-1:0]  found_value_o,
  output logic                         dropped_o
);

  localparam int unsigned IW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned PW     = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned CW     = $clog2(POOL_NODES + 1);
  localparam int unsigned MW     = chm3k_pkg::MAG_W;
  localparam int unsigned RcpMul = (32'd1 << chm3k_pkg::RCP_SHIFT) / BUCKETS;

  typedef struct packed {
    logic                          valid;
    logic                          has_next;
    logic [chm3k_pkg::KEY_W-1:0]   key;
    logic [VALUE_BITS-1:0]         value;
    logic [PW-1:0]                 next;
  } head_t;

  typedef struct packed {
    logic                          has_next;
    logic [chm3k_pkg::KEY_W-1:0]   key;
    logic [VALUE_BITS-1:0]         value;
    logic [PW-1:0]                 next;
  } node_t;

  chm3k_pkg::state_e state_q, state_d;

  logic [IW-1:0]  clr_q, clr_d;
  logic [CW-1:0]  pool_q, pool_d;
  logic           done_q, done_d;
  logic           found_q, found_d;
  logic [VALUE_BITS-1:0] fval_q, fval_d;
  logic           dropped_q, dropped_d;

  // command and hash pipeline registers
  logic                        kind_q;
  logic [chm3k_pkg::KEY_W-1:0] key_q;
  logic [VALUE_BITS-1:0]       val_q;
  logic                        neg_q;
  logic [MW-1:0]               mag_q, q_q, qb_q, rem_q;
  logic [IW-1:0]               bidx_q;
  logic [PW-1:0]               cur_q, cur_d;

  // memories
  head_t head_mem [BUCKETS];
  node_t node_mem [POOL_NODES];
  head_t head_rd_q, head_wdata;
  node_t node_rd_q, node_wdata;
  logic          head_we, head_re;
  logic [IW-1:0] head_waddr;
  logic          node_we, node_re;
  logic [PW-1:0] node_waddr, node_raddr;

  // hash arithmetic
  logic signed [7:0]  kb_hi, kb_lo;
  logic signed [15:0] prod;
  logic [15:0]        prod_abs;
  logic [31:0]        val_ext, out_ext;
  logic [31:0]        rcp_prod, qb_prod, red_diff, red_sub, idx_full;
  logic               accept;
  logic               pool_full;
  logic [PW-1:0]      pool_idx;

  assign accept    = start && !busy;
  assign kb_hi     = char_key_i[15:8];
  assign kb_lo     = char_key_i[7:0];
  assign prod      = kb_hi * kb_lo;
  assign prod_abs  = prod[15] ? (~prod + 16'd1) : prod;
  assign val_ext   = {16'd0, entry_value_i};
  assign pool_full = (pool_q == CW'(POOL_NODES));
  assign pool_idx  = pool_q[PW-1:0];

  // floor reciprocal leaves the quotient at most one short
  assign rcp_prod = 32'(mag_q) * 32'(RcpMul);
  assign qb_prod  = 32'(q_q) * 32'(BUCKETS);
  assign red_diff = 32'(mag_q) - 32'(qb_q);
  assign red_sub  = red_diff - 32'(BUCKETS);
  // negative product wraps to the non-negative remainder
  assign idx_full = (neg_q && (rem_q != '0)) ? (32'(BUCKETS) - 32'(rem_q)) : 32'(rem_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chm3k_pkg::S_CLEAR;
      clr_q   <= '0;
      pool_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pool_q  <= pool_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q   <= found_d;
    fval_q    <= fval_d;
    dropped_q <= dropped_d;
    cur_q     <= cur_d;
    if (accept) begin
      kind_q <= kind_i;
      key_q  <= char_key_i;
      val_q  <= val_ext[VALUE_BITS-1:0];
      neg_q  <= prod[15];
      mag_q  <= prod_abs[MW-1:0];
    end
    if (state_q == chm3k_pkg::S_RCP) begin
      q_q <= rcp_prod[chm3k_pkg::RCP_SHIFT +: MW];
    end
    if (state_q == chm3k_pkg::S_QB) begin
      qb_q <= qb_prod[MW-1:0];
    end
    if (state_q == chm3k_pkg::S_RED) begin
      rem_q <= (red_diff >= 32'(BUCKETS)) ? red_sub[MW-1:0] : red_diff[MW-1:0];
    end
    if (state_q == chm3k_pkg::S_IDX) begin
      bidx_q <= idx_full[IW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rd_q <= head_mem[bidx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rd_q <= node_mem[node_raddr];
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    pool_d     = pool_q;
    done_d     = 1'b0;
    found_d    = 1'b0;
    fval_d     = '0;
    dropped_d  = 1'b0;
    cur_d      = cur_q;
    head_we    = 1'b0;
    head_re    = 1'b0;
    head_waddr = bidx_q;
    head_wdata = head_rd_q;
    node_we    = 1'b0;
    node_re    = 1'b0;
    node_waddr = pool_idx;
    node_wdata = '{has_next: 1'b0, key: key_q, value: val_q, next: '0};
    node_raddr = head_rd_q.next;

    unique case (state_q)
      chm3k_pkg::S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
        head_wdata = '0;
        clr_d      = clr_q + IW'(1);
        if (clr_q == IW'(BUCKETS - 1)) begin
          state_d = chm3k_pkg::S_IDLE;
        end
      end
      chm3k_pkg::S_IDLE: begin
        if (start) begin
          state_d = chm3k_pkg::S_RCP;
        end
      end
      chm3k_pkg::S_RCP: state_d = chm3k_pkg::S_QB;
      chm3k_pkg::S_QB:  state_d = chm3k_pkg::S_RED;
      chm3k_pkg::S_RED: state_d = chm3k_pkg::S_IDX;
      chm3k_pkg::S_IDX: state_d = chm3k_pkg::S_HRD;
      chm3k_pkg::S_HRD: begin
        head_re = 1'b1;
        state_d = chm3k_pkg::S_HEAD;
      end
      chm3k_pkg::S_HEAD: begin
        state_d = chm3k_pkg::S_IDLE;
        done_d  = 1'b1;
        if (kind_q) begin
          priority if (!head_rd_q.valid) begin
            head_we    = 1'b1;
            head_wdata = '{valid: 1'b1, has_next: 1'b0, key: key_q, value: val_q,
                           next: '0};
          end else if (head_rd_q.value == val_q) begin
            // same value at head: nothing to do
          end else if (pool_full) begin
            dropped_d = 1'b1;
          end else if (!head_rd_q.has_next) begin
            node_we             = 1'b1;
            head_we             = 1'b1;
            head_wdata.has_next = 1'b1;
            head_wdata.next     = pool_idx;
            pool_d              = pool_q + CW'(1);
          end else begin
            node_re = 1'b1;
            cur_d   = head_rd_q.next;
            done_d  = 1'b0;
            state_d = chm3k_pkg::S_NODE;
          end
        end else begin
          priority if (!head_rd_q.valid) begin
            // empty bucket: miss
          end else if (head_rd_q.key == key_q) begin
            found_d = 1'b1;
            fval_d  = head_rd_q.value;
          end else if (head_rd_q.has_next) begin
            node_re = 1'b1;
            done_d  = 1'b0;
            state_d = chm3k_pkg::S_NODE;
          end else begin
            // end of chain: miss
          end
        end
      end
      chm3k_pkg::S_NODE: begin
        node_raddr = node_rd_q.next;
        if (kind_q) begin
          if (node_rd_q.has_next) begin
            node_re = 1'b1;
            cur_d   = node_rd_q.next;
          end else begin
            // new node first, tail link on the next cycle
            node_we = 1'b1;
            state_d = chm3k_pkg::S_LINK;
          end
        end else begin
          priority if (node_rd_q.key == key_q) begin
            found_d = 1'b1;
            fval_d  = node_rd_q.value;
            done_d  = 1'b1;
            state_d = chm3k_pkg::S_IDLE;
          end else if (node_rd_q.has_next) begin
            node_re = 1'b1;
          end else begin
            done_d  = 1'b1;
            state_d = chm3k_pkg::S_IDLE;
          end
        end
      end
      chm3k_pkg::S_LINK: begin
        node_we             = 1'b1;
        node_waddr          = cur_q;
        node_wdata          = node_rd_q;
        node_wdata.has_next = 1'b1;
        node_wdata.next     = pool_idx;
        pool_d              = pool_q + CW'(1);
        done_d              = 1'b1;
        state_d             = chm3k_pkg::S_IDLE;
      end
      default: state_d = chm3k_pkg::S_IDLE;
    endcase
  end

  assign out_ext       = 32'(fval_q);
  assign busy          = (state_q != chm3k_pkg::S_IDLE);
  assign done_o        = done_q;
  assign found_o       = found_q;
  assign found_value_o = out_ext[chm3k_pkg::VAL_W-1:0];
  assign dropped_o     = dropped_q;

endmodule

/* rtl/core/chm3k_checker.sv */
// port-level checker for the chained hash map unit, bound to the top level
// depends on chm3k_pkg and chained_hash_map_3byte_key_unit
module chm3k_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic                        found_o,
  input logic [chm3k_pkg::VAL_W-1:0] found_value_o,
  input logic                        dropped_o
);

  // an accepted command word keeps the unit busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (found_value_o == '0))
    else $error("nonzero value without a match");

  a_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && dropped_o) |-> !found_o)
    else $error("dropped and found together");

endmodule

bind chained_hash_map_3byte_key_unit chm3k_checker u_chm3k_checker (.*);
